// ===== design/mpdm_pkg.sv =====
// ----------------------------------------------------------------------------
// mpdm_pkg: shared types and constants of the multi-pattern DFA matcher
// Item kinds, action codes and the front-to-back queue entry.
// ----------------------------------------------------------------------------
package mpdm_pkg;

  localparam int NumStatesDef   = 1024;
  localparam int AlphabetDef    = 256;
  localparam int MatchEntriesDef = 4096;
  localparam int MaxMatchesDef  = 16;
  localparam int PatternIdsDef  = 1024;

  localparam logic [2:0] KIND_SCAN  = 3'd0;
  localparam logic [2:0] KIND_TRANS = 3'd1;
  localparam logic [2:0] KIND_RANGE = 3'd2;
  localparam logic [2:0] KIND_ENTRY = 3'd3;
  localparam logic [2:0] KIND_CTX   = 3'd4;

  localparam logic [1:0] ACT_REPORT = 2'd0;
  localparam logic [1:0] ACT_STOP   = 2'd1;

  // Queued item from front to back
  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  data_byte;
    logic        last_in_buffer;
    logic [9:0]  state_index;
    logic [9:0]  next_state;
    logic [11:0] match_start;
    logic [4:0]  match_count;
    logic [11:0] entry_index;
    logic [9:0]  pattern_id;
    logic [1:0]  action;
  } mpdm_item_t;

endpackage

// ===== design/multi_pattern_dfa_matcher.sv =====
// ----------------------------------------------------------------------------
// multi_pattern_dfa_matcher: Aho-Corasick DFA byte-stream matcher
// Front queue takes command items; back sequencer walks tables and reports.
// ----------------------------------------------------------------------------
// In the back end a table load is done in idle; a scanned byte goes through
// transition read, range read, range setup, the range's entries in turn, a
// range end check and a report flush; a stop skips the end check, and the last
// byte adds a summary. A skipped byte is done in idle. A 2-entry queue takes
// start while the back end works. Reset first sweeps the match-count store.
// Results appear on result_valid for one cycle; the receiver cannot stall.
module multi_pattern_dfa_matcher
  import mpdm_pkg::*;
#(
  parameter int NUM_STATES            = NumStatesDef,
  parameter int ALPHABET              = AlphabetDef,
  parameter int MATCH_ENTRIES         = MatchEntriesDef,
  parameter int MAX_MATCHES_PER_STATE = MaxMatchesDef
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  kind,
  input  logic [7:0]  data_byte,
  input  logic        last_in_buffer,
  input  logic [9:0]  state_index,
  input  logic [9:0]  next_state,
  input  logic [11:0] match_start,
  input  logic [4:0]  match_count,
  input  logic [11:0] entry_index,
  input  logic [9:0]  pattern_id,
  input  logic [1:0]  action,
  output logic        result_valid,
  output logic        result_kind,
  output logic [9:0]  found_pattern,
  output logic [15:0] buffer_matches,
  output logic        stopped,
  output logic        last
);

  mpdm_item_t item_in;
  mpdm_item_t q_item;
  logic       q_valid;
  logic       q_pop;

  assign item_in = '{kind: kind, data_byte: data_byte, last_in_buffer: last_in_buffer,
                     state_index: state_index, next_state: next_state,
                     match_start: match_start, match_count: match_count,
                     entry_index: entry_index, pattern_id: pattern_id,
                     action: action};

  mpdm_front u_front (
    .clk, .rst, .start, .item_in, .busy, .q_valid, .q_item, .q_pop
  );

  mpdm_back #(
    .NUM_STATES(NUM_STATES), .ALPHABET(ALPHABET),
    .MATCH_ENTRIES(MATCH_ENTRIES), .MAX_MATCHES_PER_STATE(MAX_MATCHES_PER_STATE)
  ) u_back (
    .clk, .rst, .q_valid, .q_item, .q_pop, .result_valid, .result_kind,
    .found_pattern, .buffer_matches, .stopped, .last
  );

endmodule

// ===== design/mpdm_front.sv =====
// ----------------------------------------------------------------------------
// mpdm_front: item intake
// Accepts command items, drops unused kinds, and queues the rest (2 deep).
// ----------------------------------------------------------------------------
module mpdm_front
  import mpdm_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  mpdm_item_t item_in,
  output logic       busy,
  output logic       q_valid,
  output mpdm_item_t q_item,
  input  logic       q_pop
);

  mpdm_item_t slot [2];
  logic       rd_ptr;
  logic       wr_ptr;
  logic [1:0] fill;
  logic       push;
  logic       do_pop;

  assign busy    = (fill == 2'd2);
  assign q_valid = (fill != 2'd0);
  assign q_item  = slot[rd_ptr];
  assign do_pop  = q_pop && q_valid;
  // kinds above reset-context do nothing and are not queued
  assign push    = start && !busy && (item_in.kind <= KIND_CTX);

  always_ff @(posedge clk) begin
    if (push) slot[wr_ptr] <= item_in;
  end

  // queue pointers and fill
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (do_pop) rd_ptr <= ~rd_ptr;
      fill <= fill + {1'b0, push} - {1'b0, do_pop};
    end
  end

  a_fill_max: assert property (@(posedge clk) disable iff (rst) fill <= 2'd2)
    else $error("queue overfilled");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    (fill == 2'd0) |-> !do_pop) else $error("pop of empty queue");
  a_push_full: assert property (@(posedge clk) disable iff (rst)
    (fill == 2'd2) |-> !push) else $error("push into full queue");

endmodule

// ===== design/mpdm_back.sv =====
// ----------------------------------------------------------------------------
// mpdm_back: table storage and scan sequencer
// Writes tables, walks the DFA and emits match reports and summaries.
// ----------------------------------------------------------------------------
module mpdm_back
  import mpdm_pkg::*;
#(
  parameter int NUM_STATES            = NumStatesDef,
  parameter int ALPHABET              = AlphabetDef,
  parameter int MATCH_ENTRIES         = MatchEntriesDef,
  parameter int MAX_MATCHES_PER_STATE = MaxMatchesDef
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        q_valid,
  input  mpdm_item_t  q_item,
  output logic        q_pop,
  output logic        result_valid,
  output logic        result_kind,
  output logic [9:0]  found_pattern,
  output logic [15:0] buffer_matches,
  output logic        stopped,
  output logic        last
);

  localparam int SW = (NUM_STATES > 1) ? $clog2(NUM_STATES) : 1;
  localparam int AW = (ALPHABET > 1) ? $clog2(ALPHABET) : 1;
  localparam int EW = (MATCH_ENTRIES > 1) ? $clog2(MATCH_ENTRIES) : 1;
  localparam int CW = $clog2(MAX_MATCHES_PER_STATE + 1);
  localparam int TD = NUM_STATES * (2 ** AW);
  localparam int CLRW = SW + 1;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_TRANS = 3'd2;
  localparam logic [2:0] S_RANGE = 3'd3;
  localparam logic [2:0] S_ENTRY = 3'd4;
  localparam logic [2:0] S_SCAN  = 3'd5;
  localparam logic [2:0] S_SUM   = 3'd6;
  localparam logic [2:0] S_FLUSH = 3'd7;

  // memories
  logic [SW-1:0] trans_mem [TD];
  logic [11:0]   mstart_mem [NUM_STATES];
  logic [CW-1:0] mcount_mem [NUM_STATES];
  logic [11:0]   entry_mem [MATCH_ENTRIES];

  logic [2:0]      state;
  logic [CLRW-1:0] clr_addr;
  logic [SW-1:0]   cur;
  logic            skipping;
  logic [15:0]     counter;
  logic [SW-1:0]   trans_q;
  logic [11:0]     mstart_q;
  logic [CW-1:0]   mcount_q;
  logic [11:0]     entry_q;
  logic [CW-1:0]   k;
  logic            last_q;
  logic            in_range;
  logic [12:0]     e_addr;
  logic [15:0]     cnt_inc;
  logic            pend_valid;
  logic [9:0]      pend_pat;
  logic [15:0]     pend_cnt;
  logic            pend_stop;

  logic [SW-1:0] st_idx;
  logic [AW:0]   sym_ext;
  logic          sym_ok;
  logic          trans_wr_ok;
  logic          range_wr_ok;
  logic          entry_wr_ok;
  logic [4:0]    mc_sat;
  logic [12:0]   e_next;

  assign st_idx  = SW'(q_item.state_index);
  assign sym_ext = (AW + 1)'(q_item.data_byte);
  assign sym_ok  = 32'(q_item.data_byte) < ALPHABET;
  assign trans_wr_ok = (32'(q_item.state_index) < NUM_STATES) && sym_ok &&
                       (32'(q_item.next_state) < NUM_STATES);
  assign range_wr_ok = 32'(q_item.state_index) < NUM_STATES;
  assign entry_wr_ok = 32'(q_item.entry_index) < MATCH_ENTRIES;
  assign mc_sat = (32'(q_item.match_count) > MAX_MATCHES_PER_STATE) ?
                  5'(MAX_MATCHES_PER_STATE) : q_item.match_count;
  assign q_pop = (state == S_IDLE) && q_valid;
  assign e_addr = {1'b0, mstart_q} + 13'(k);
  assign in_range = (32'(k) < 32'(mcount_q)) && (32'(e_addr) < MATCH_ENTRIES);
  assign cnt_inc = (counter == 16'hFFFF) ? counter : counter + 16'd1;
  assign e_next = {1'b0, mstart_q} + 13'(k) + 13'd1;

  // transition table: one write or one lookup per cycle, on an item popped in idle
  always_ff @(posedge clk) begin
    if (q_pop && q_item.kind == KIND_TRANS && trans_wr_ok)
      trans_mem[{st_idx, sym_ext[AW-1:0]}] <= SW'(q_item.next_state);
    if (q_pop && q_item.kind == KIND_SCAN && !skipping) begin
      // a symbol outside the alphabet goes back to root
      if (sym_ok) trans_q <= trans_mem[{cur, sym_ext[AW-1:0]}];
      else trans_q <= '0;
    end
  end

  // match entry store, read at the range start and then at the next entry of the range
  always_ff @(posedge clk) begin
    if (q_pop && q_item.kind == KIND_ENTRY && entry_wr_ok)
      entry_mem[EW'(q_item.entry_index)] <= {q_item.action, q_item.pattern_id};
    if (state == S_RANGE && 32'(mstart_q) < MATCH_ENTRIES)
      entry_q <= entry_mem[EW'(mstart_q)];
    else if (state == S_SCAN && 32'(e_next) < MATCH_ENTRIES)
      entry_q <= entry_mem[EW'(e_next)];
  end

  // per-state range; count store is cleared by a sweep after reset
  always_ff @(posedge clk) begin
    if (state == S_CLEAR)
      mcount_mem[SW'(clr_addr)] <= '0;
    else if (q_pop && q_item.kind == KIND_RANGE && range_wr_ok) begin
      mcount_mem[st_idx] <= CW'(mc_sat);
      mstart_mem[st_idx] <= q_item.match_start;
    end
    if (state == S_TRANS) begin
      mstart_q <= mstart_mem[trans_q];
      mcount_q <= mcount_mem[trans_q];
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      clr_addr     <= '0;
      cur          <= '0;
      skipping     <= 1'b0;
      counter      <= '0;
      k            <= '0;
      last_q       <= 1'b0;
      result_valid <= 1'b0;
      pend_valid   <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (32'(clr_addr) == NUM_STATES - 1) state <= S_IDLE;
        end
        S_IDLE: begin
          if (q_pop) begin
            if (q_item.kind == KIND_CTX) begin
              cur <= '0; skipping <= 1'b0; counter <= '0;
            end else if (q_item.kind == KIND_SCAN) begin
              last_q <= q_item.last_in_buffer;
              if (skipping) begin
                if (q_item.last_in_buffer) begin
                  result_valid <= 1'b1; result_kind <= 1'b1;
                  found_pattern <= '0; buffer_matches <= counter;
                  stopped <= 1'b1; last <= 1'b1;
                  counter <= '0; skipping <= 1'b0;
                end
              end else begin
                state <= S_TRANS;
              end
            end
          end
        end
        S_TRANS: begin
          cur <= trans_q;
          state <= S_RANGE;
        end
        S_RANGE: begin
          // mstart_q/mcount_q now hold the new state's range
          k <= '0;
          state <= S_SCAN;
        end
        S_SCAN: begin
          if (!in_range) begin
            state <= S_FLUSH;
          end else begin
            k <= k + 1'b1;
            if (entry_q[11:10] == ACT_REPORT || entry_q[11:10] == ACT_STOP) begin
              counter <= cnt_inc;
              // each report is held until the next one or the flush so its last flag is known
              if (pend_valid) begin
                result_valid <= 1'b1; result_kind <= 1'b0;
                found_pattern <= pend_pat; buffer_matches <= pend_cnt;
                stopped <= 1'b0; last <= 1'b0;
              end
              pend_valid <= 1'b1;
              pend_pat   <= entry_q[9:0];
              pend_cnt   <= cnt_inc;
              pend_stop  <= (entry_q[11:10] == ACT_STOP);
              if (entry_q[11:10] == ACT_STOP) begin
                cur <= '0; skipping <= 1'b1;
                state <= S_FLUSH;
              end
            end
          end
        end
        S_FLUSH: begin
          // final held report; a summary follows on the last byte
          if (pend_valid) begin
            result_valid <= 1'b1; result_kind <= 1'b0;
            found_pattern <= pend_pat; buffer_matches <= pend_cnt;
            stopped <= pend_stop; last <= !last_q;
            pend_valid <= 1'b0;
          end
          state <= last_q ? S_SUM : S_IDLE;
        end
        S_SUM: begin
          result_valid <= 1'b1; result_kind <= 1'b1;
          found_pattern <= '0; buffer_matches <= counter;
          stopped <= skipping; last <= 1'b1; counter <= '0;
          skipping <= 1'b0;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> state == S_IDLE) else $error("pop outside idle");
  a_skip_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> !skipping) else $error("scan while skipping");
  a_sum_zero: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_kind) |-> found_pattern == '0)
    else $error("summary with pattern");

endmodule
